/* src/mer_pkg.sv */
`default_nettype none

package mer_pkg;

  localparam int unsigned SENSORS_DEF = 4;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned SENS_W    = 4;
  localparam int unsigned RIDX_W    = 8;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned TMO_W     = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = $clog2(TICK_W);

  localparam logic [DIST_W-1:0] TPU_RST    = DIST_W'(148);
  localparam logic [TMO_W-1:0]  TMO_RST    = TMO_W'(38000);
  localparam logic [DIST_W-1:0] MAXR_RST   = DIST_W'(400);
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(TICK_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_UNIT = 2'd0,
    CFG_TIMEOUT_TICKS  = 2'd1,
    CFG_MAX_RANGE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_RISE  = 3'd1,
    OP_FALL  = 3'd2,
    OP_READ  = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RDNEAR,
    ST_CMP,
    ST_RDOUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              fire_trigger;
    logic [SENS_W-1:0] trigger_sensor;
    logic              measured;
    logic              timed_out;
    logic [DIST_W-1:0] measured_distance;
    logic              read_valid;
    logic [DIST_W-1:0] read_distance;
    logic [SENS_W-1:0] closest_sensor;
    logic [SENS_W-1:0] current_sensor;
  } res_t;

endpackage

`default_nettype wire

/* src/mer_ram.sv */
`default_nettype none

module mer_ram #(
  parameter int unsigned WIDTH = mer_pkg::DIST_W,
  parameter int unsigned DEPTH = mer_pkg::SENSORS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/multiplexed_echo_ranger_top.sv */
// Multiplexed echo ranger: scans SENSORS ultrasonic rangers in turn.
// Input channel (in_valid_i/in_ready_o) carries one transaction per event:
// tick, echo rising, echo falling, distance read or scan start. Output
// channel (out_valid_o/out_ready_i) returns exactly one result per input
// transaction, in order. Configuration is a plain write port
// (cfg_we_i, cfg_index_i, cfg_data_i), taken at once, no read-back.
// One transaction is processed at a time. Tick, rise, start and ignored
// transactions pass from acceptance through an execute state to the output
// load; a read of a valid index adds a state for the registered memory read.
// A falling edge on the current sensor is launched, runs through the
// bit-serial divider (one quotient bit per cycle), reads the closest
// sensor's distance from memory, does the compare and write-back and then
// loads the output register; a zero divisor skips the divider.
// The block returns to idle in the cycle after loading the result and
// takes a new transaction only then. The next transaction is accepted even
// if the receiver still stalls the output register; a further result then
// waits until it is taken.
// Reset clears all counters, the scan position, the closest index, and the
// per-sensor valid bits, so every stored distance reads as zero after reset.
`default_nettype none

module multiplexed_echo_ranger_top #(
  parameter int unsigned SENSORS = mer_pkg::SENSORS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mer_pkg::OP_W-1:0]       operation_i,
  input  wire logic [mer_pkg::SENS_W-1:0]     echo_sensor_i,
  input  wire logic [mer_pkg::RIDX_W-1:0]     read_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                fire_trigger_o,
  output logic      [mer_pkg::SENS_W-1:0]     trigger_sensor_o,
  output logic                                measured_o,
  output logic                                timed_out_o,
  output logic      [mer_pkg::DIST_W-1:0]     measured_distance_o,
  output logic                                read_valid_o,
  output logic      [mer_pkg::DIST_W-1:0]     read_distance_o,
  output logic      [mer_pkg::SENS_W-1:0]     closest_sensor_o,
  output logic      [mer_pkg::SENS_W-1:0]     current_sensor_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mer_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [mer_pkg::SENS_W-1:0] LAST_SENS = mer_pkg::SENS_W'(SENSORS - 1);
  localparam logic [mer_pkg::RIDX_W-1:0] SENS_CNT  = mer_pkg::RIDX_W'(SENSORS);

  mer_pkg::state_e state_q, state_d;

  logic [mer_pkg::DIST_W-1:0] tpu_q;
  logic [mer_pkg::TMO_W-1:0]  tmo_q;
  logic [mer_pkg::DIST_W-1:0] maxr_q;

  logic [mer_pkg::OP_W-1:0]   op_q, op_d;
  logic [mer_pkg::SENS_W-1:0] esens_q, esens_d;
  logic [mer_pkg::RIDX_W-1:0] ridx_q, ridx_d;

  logic [mer_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [mer_pkg::TICK_W-1:0] rise_q, rise_d;
  logic [mer_pkg::SENS_W-1:0] active_q, active_d;
  logic [mer_pkg::SENS_W-1:0] nearest_q, nearest_d;
  logic                       armed_q, armed_d;
  logic [mer_pkg::TMO_W-1:0]  left_q, left_d;
  logic [SENSORS-1:0]         vld_q, vld_d;

  logic [mer_pkg::DIST_W-1:0] rem_q, rem_d;
  logic [mer_pkg::TICK_W-1:0] quo_q, quo_d;
  logic [mer_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  mer_pkg::res_t res_q, res_d;
  mer_pkg::res_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [mer_pkg::DIST_W-1:0] ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [mer_pkg::DIST_W-1:0] ram_rdata;

  logic [mer_pkg::SENS_W-1:0] next_act;
  logic [mer_pkg::DIST_W:0]   trial;
  logic [mer_pkg::DIST_W:0]   trial_sub;
  logic                       trial_ge;
  logic [mer_pkg::DIST_W-1:0] dist_sat;
  logic [mer_pkg::DIST_W-1:0] near_dist;

  mer_ram #(
    .WIDTH (mer_pkg::DIST_W),
    .DEPTH (SENSORS)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign next_act  = (active_q == LAST_SENS) ? '0 : active_q + 1'b1;
  assign trial     = {rem_q, quo_q[mer_pkg::TICK_W-1]};
  assign trial_ge  = trial >= {1'b0, tpu_q};
  assign trial_sub = trial - {1'b0, tpu_q};
  assign dist_sat  = (|quo_q[mer_pkg::TICK_W-1:mer_pkg::DIST_W]) ? '1
                                                                 : quo_q[mer_pkg::DIST_W-1:0];
  assign near_dist = vld_q[nearest_q[IDX_W-1:0]] ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q  <= mer_pkg::TPU_RST;
      tmo_q  <= mer_pkg::TMO_RST;
      maxr_q <= mer_pkg::MAXR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mer_pkg::CFG_TICKS_PER_UNIT: tpu_q  <= cfg_data_i[mer_pkg::DIST_W-1:0];
        mer_pkg::CFG_TIMEOUT_TICKS:  tmo_q  <= cfg_data_i[mer_pkg::TMO_W-1:0];
        mer_pkg::CFG_MAX_RANGE:      maxr_q <= cfg_data_i[mer_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mer_pkg::ST_IDLE;
      tick_q      <= '0;
      rise_q      <= '0;
      active_q    <= '0;
      nearest_q   <= '0;
      armed_q     <= 1'b0;
      left_q      <= '0;
      vld_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      rise_q      <= rise_d;
      active_q    <= active_d;
      nearest_q   <= nearest_d;
      armed_q     <= armed_d;
      left_q      <= left_d;
      vld_q       <= vld_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    esens_q <= esens_d;
    ridx_q  <= ridx_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    esens_d     = esens_q;
    ridx_d      = ridx_q;
    tick_d      = tick_q;
    rise_d      = rise_q;
    active_d    = active_q;
    nearest_d   = nearest_q;
    armed_d     = armed_q;
    left_d      = left_q;
    vld_d       = vld_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = active_q[IDX_W-1:0];
    ram_wdata   = dist_sat;
    ram_raddr   = ridx_q[IDX_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mer_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = operation_i;
          esens_d = echo_sensor_i;
          ridx_d  = read_index_i;
          state_d = mer_pkg::ST_EXEC;
        end
      end

      mer_pkg::ST_EXEC: begin
        res_d   = '0;
        state_d = mer_pkg::ST_DONE;
        unique case (op_q)
          mer_pkg::OP_TICK: begin
            tick_d = tick_q + 1'b1;
            if (armed_q) begin
              if (left_q <= mer_pkg::TMO_W'(1)) begin
                left_d                  = '0;
                armed_d                 = 1'b0;
                ram_we                  = 1'b1;
                ram_wdata               = maxr_q;
                vld_d[active_q[IDX_W-1:0]] = 1'b1;
                res_d.measured          = 1'b1;
                res_d.timed_out         = 1'b1;
                res_d.measured_distance = maxr_q;
                res_d.fire_trigger      = 1'b1;
                res_d.trigger_sensor    = next_act;
                active_d                = next_act;
              end else begin
                left_d = left_q - 1'b1;
              end
            end
          end
          mer_pkg::OP_RISE: begin
            if (esens_q == active_q) begin
              rise_d  = tick_q;
              left_d  = tmo_q;
              armed_d = 1'b1;
            end
          end
          mer_pkg::OP_FALL: begin
            if (esens_q == active_q) begin
              armed_d = 1'b0;
              left_d  = '0;
              rem_d   = '0;
              cnt_d   = '0;
              if (tpu_q == '0) begin
                quo_d   = '1;
                state_d = mer_pkg::ST_RDNEAR;
              end else begin
                quo_d   = tick_q - rise_q;
                state_d = mer_pkg::ST_DIV;
              end
            end
          end
          mer_pkg::OP_READ: begin
            if (ridx_q < SENS_CNT) begin
              state_d = mer_pkg::ST_RDOUT;
            end
          end
          mer_pkg::OP_START: begin
            armed_d              = 1'b0;
            left_d               = '0;
            active_d             = '0;
            res_d.fire_trigger   = 1'b1;
            res_d.trigger_sensor = '0;
          end
          default: ;
        endcase
      end

      mer_pkg::ST_DIV: begin
        rem_d = trial_ge ? trial_sub[mer_pkg::DIST_W-1:0] : trial[mer_pkg::DIST_W-1:0];
        quo_d = {quo_q[mer_pkg::TICK_W-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mer_pkg::DIV_LAST) begin
          state_d = mer_pkg::ST_RDNEAR;
        end
      end

      mer_pkg::ST_RDNEAR: begin
        ram_raddr = nearest_q[IDX_W-1:0];
        state_d   = mer_pkg::ST_CMP;
      end

      mer_pkg::ST_CMP: begin
        ram_we                     = 1'b1;
        vld_d[active_q[IDX_W-1:0]] = 1'b1;
        if (dist_sat < near_dist) begin
          nearest_d = active_q;
        end
        res_d.measured          = 1'b1;
        res_d.measured_distance = dist_sat;
        res_d.fire_trigger      = 1'b1;
        res_d.trigger_sensor    = next_act;
        active_d                = next_act;
        state_d                 = mer_pkg::ST_DONE;
      end

      mer_pkg::ST_RDOUT: begin
        res_d.read_valid    = 1'b1;
        res_d.read_distance = vld_q[ridx_q[IDX_W-1:0]] ? ram_rdata : '0;
        state_d             = mer_pkg::ST_DONE;
      end

      mer_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d                = res_q;
          out_d.closest_sensor = nearest_q;
          out_d.current_sensor = active_q;
          out_valid_d          = 1'b1;
          state_d              = mer_pkg::ST_IDLE;
        end
      end

      default: state_d = mer_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign fire_trigger_o      = out_q.fire_trigger;
  assign trigger_sensor_o    = out_q.trigger_sensor;
  assign measured_o          = out_q.measured;
  assign timed_out_o         = out_q.timed_out;
  assign measured_distance_o = out_q.measured_distance;
  assign read_valid_o        = out_q.read_valid;
  assign read_distance_o     = out_q.read_distance;
  assign closest_sensor_o    = out_q.closest_sensor;
  assign current_sensor_o    = out_q.current_sensor;

endmodule

`default_nettype wire

/* src/mer_checker.sv */
`default_nettype none

module mer_checker #(
  parameter int unsigned SENSORS = mer_pkg::SENSORS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          fire_trigger_o,
  input wire logic [mer_pkg::SENS_W-1:0]    trigger_sensor_o,
  input wire logic                          measured_o,
  input wire logic                          timed_out_o,
  input wire logic [mer_pkg::DIST_W-1:0]    measured_distance_o,
  input wire logic                          read_valid_o,
  input wire logic [mer_pkg::DIST_W-1:0]    read_distance_o,
  input wire logic [mer_pkg::SENS_W-1:0]    closest_sensor_o,
  input wire logic [mer_pkg::SENS_W-1:0]    current_sensor_o
);

  localparam logic [mer_pkg::SENS_W:0] SENS_CNT = (mer_pkg::SENS_W + 1)'(SENSORS);

  logic [mer_pkg::SENS_W:0] cur_ext;
  logic [mer_pkg::SENS_W:0] near_ext;

  assign cur_ext  = {1'b0, current_sensor_o};
  assign near_ext = {1'b0, closest_sensor_o};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(measured_distance_o)
      && $stable(read_distance_o) && $stable(current_sensor_o)
      && $stable(trigger_sensor_o))
    else $error("stalled result changed");

  a_timeout_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timed_out_o |-> measured_o && fire_trigger_o)
    else $error("timeout result without measurement and trigger");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> !measured_o && !fire_trigger_o)
    else $error("read result carries a measurement or trigger");

  a_sensor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cur_ext < SENS_CNT && near_ext < SENS_CNT)
    else $error("sensor index out of range");

endmodule

bind multiplexed_echo_ranger_top mer_checker #(.SENSORS(SENSORS)) u_mer_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mer_pkg::*;

  localparam int unsigned SENSORS       = SENSORS_DEF;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 425;
  localparam int unsigned BURST_TICKS   = 200;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SENS_W-1:0] es;
    logic [RIDX_W-1:0] ri;
    bit                typed;
    res_t              want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  logic [SENS_W-1:0] echo_sel = '0;
  logic [RIDX_W-1:0] rd_idx = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              fire, meas, tout, rvalid;
  logic [SENS_W-1:0] tsens, closest, current;
  logic [DIST_W-1:0] mdist, rdist;
  logic              cfg_we = 1'b0;
  cfg_idx_e          cfg_sel = CFG_TICKS_PER_UNIT;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic [DIST_W-1:0] tpu_reg = TPU_RST;
  logic [TMO_W-1:0]  tmo_reg = TMO_RST;
  logic [DIST_W-1:0] maxr_reg = MAXR_RST;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [TICK_W-1:0] rise_stamp = '0;
  logic [SENS_W-1:0] scan_pos = '0;
  logic [SENS_W-1:0] nearest = '0;
  logic              armed = 1'b0;
  logic [TMO_W-1:0]  countdown = '0;
  logic [DIST_W-1:0] dist_mem [SENSORS] = '{default: '0};

  res_t        pending_results[$];
  stim_row_t   dir_rows[$];
  int unsigned errors = 0;
  bit          cur_typed = 1'b0;
  res_t        cur_want = '0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_go = 1'b0;

  multiplexed_echo_ranger_top #(.SENSORS(SENSORS)) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (op),
    .echo_sensor_i      (echo_sel),
    .read_index_i       (rd_idx),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .fire_trigger_o     (fire),
    .trigger_sensor_o   (tsens),
    .measured_o         (meas),
    .timed_out_o        (tout),
    .measured_distance_o(mdist),
    .read_valid_o       (rvalid),
    .read_distance_o    (rdist),
    .closest_sensor_o   (closest),
    .current_sensor_o   (current),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_sel),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [SENS_W-1:0] following(logic [SENS_W-1:0] s);
    return (s == SENS_W'(SENSORS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic res_t ranger_step(logic [OP_W-1:0] opc, logic [SENS_W-1:0] es,
                                       logic [RIDX_W-1:0] ri);
    res_t              r;
    logic [TICK_W-1:0] quot;
    logic [DIST_W-1:0] d;
    r = '0;
    case (opc)
      OP_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        if (armed) begin
          if (countdown <= 1) begin
            countdown = '0;
            armed = 1'b0;
            dist_mem[scan_pos] = maxr_reg;
            r.measured = 1'b1;
            r.timed_out = 1'b1;
            r.measured_distance = maxr_reg;
            scan_pos = following(scan_pos);
            r.fire_trigger = 1'b1;
            r.trigger_sensor = scan_pos;
          end else begin
            countdown = countdown - 1'b1;
          end
        end
      end
      OP_RISE: begin
        if (es == scan_pos) begin
          rise_stamp = tick_cnt;
          countdown = tmo_reg;
          armed = 1'b1;
        end
      end
      OP_FALL: begin
        if (es == scan_pos) begin
          quot = (tpu_reg == '0) ? '1 : (tick_cnt - rise_stamp) / TICK_W'(tpu_reg);
          d = (quot > TICK_W'(16'hFFFF)) ? '1 : quot[DIST_W-1:0];
          armed = 1'b0;
          countdown = '0;
          dist_mem[scan_pos] = d;
          if (d < dist_mem[nearest]) nearest = scan_pos;
          r.measured = 1'b1;
          r.measured_distance = d;
          scan_pos = following(scan_pos);
          r.fire_trigger = 1'b1;
          r.trigger_sensor = scan_pos;
        end
      end
      OP_READ: begin
        if (ri < SENSORS) begin
          r.read_valid = 1'b1;
          r.read_distance = dist_mem[ri];
        end
      end
      OP_START: begin
        armed = 1'b0;
        countdown = '0;
        scan_pos = '0;
        r.fire_trigger = 1'b1;
        r.trigger_sensor = '0;
      end
      default: ;
    endcase
    r.closest_sensor = nearest;
    r.current_sensor = scan_pos;
    return r;
  endfunction

  function automatic res_t result_of(bit f, logic [SENS_W-1:0] ts, bit m, bit t,
                                     logic [DIST_W-1:0] md, bit rv, logic [DIST_W-1:0] rd,
                                     logic [SENS_W-1:0] cl, logic [SENS_W-1:0] cu);
    return {f, ts, m, t, md, rv, rd, cl, cu};
  endfunction

  function automatic stim_row_t row(logic [OP_W-1:0] opc, logic [SENS_W-1:0] es,
                                    logic [RIDX_W-1:0] ri, bit typed = 1'b0,
                                    res_t want = '0);
    stim_row_t r;
    r.op = opc;
    r.es = es;
    r.ri = ri;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf({"fire=%0d tsens=%0d meas=%0d tout=%0d mdist=%0d ",
                      "rvalid=%0d rdist=%0d closest=%0d current=%0d"},
                     r.fire_trigger, r.trigger_sensor, r.measured, r.timed_out,
                     r.measured_distance, r.read_valid, r.read_distance,
                     r.closest_sensor, r.current_sensor);
  endfunction

  always @(posedge clk) begin
    res_t  want;
    res_t  got;
    string bad;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_sel)
          CFG_TICKS_PER_UNIT: tpu_reg = cfg_data[DIST_W-1:0];
          CFG_TIMEOUT_TICKS:  tmo_reg = cfg_data[TMO_W-1:0];
          CFG_MAX_RANGE:      maxr_reg = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = ranger_step(op, echo_sel, rd_idx);
        pending_results.push_back(cur_typed ? cur_want : want);
      end
      if (out_valid && out_ready) begin
        got = {fire, tsens, meas, tout, mdist, rvalid, rdist, closest, current};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $display("unexpected result at %0t: %s", $time, show(got));
        end else begin
          want = pending_results.pop_front();
          bad = "";
          if (got.fire_trigger !== want.fire_trigger) bad = {bad, " fire_trigger"};
          if (got.trigger_sensor !== want.trigger_sensor) bad = {bad, " trigger_sensor"};
          if (got.measured !== want.measured) bad = {bad, " measured"};
          if (got.timed_out !== want.timed_out) bad = {bad, " timed_out"};
          if (got.measured_distance !== want.measured_distance) bad = {bad, " measured_distance"};
          if (got.read_valid !== want.read_valid) bad = {bad, " read_valid"};
          if (got.read_distance !== want.read_distance) bad = {bad, " read_distance"};
          if (got.closest_sensor !== want.closest_sensor) bad = {bad, " closest_sensor"};
          if (got.current_sensor !== want.current_sensor) bad = {bad, " current_sensor"};
          if (bad != "") begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch at %0t in%s", $time, bad);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

  initial begin
    bit          rdy_next;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rdy_next = 1'b0;
        hold_left--;
      end else begin
        rdy_next = ($urandom_range(99) >= stall_pct);
      end
      @(negedge clk);
      out_ready <= rdy_next;
    end
  end

  task automatic issue(input logic [OP_W-1:0] opc, input logic [SENS_W-1:0] es,
                       input logic [RIDX_W-1:0] ri, input bit typed = 1'b0,
                       input res_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    echo_sel <= es;
    rd_idx <= ri;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) begin
      issue(dir_rows[i].op, dir_rows[i].es, dir_rows[i].ri, dir_rows[i].typed,
            dir_rows[i].want);
    end
    dir_rows.delete();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [DIST_W-1:0] tpu, input logic [TMO_W-1:0] tmo,
                           input logic [DIST_W-1:0] maxr);
    cfg_we <= 1'b1;
    cfg_sel <= CFG_TICKS_PER_UNIT;
    cfg_data <= CFG_W'(tpu);
    @(negedge clk);
    cfg_sel <= CFG_TIMEOUT_TICKS;
    cfg_data <= CFG_W'(tmo);
    @(negedge clk);
    cfg_sel <= CFG_MAX_RANGE;
    cfg_data <= CFG_W'(maxr);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned       cnt;
    int unsigned       n;
    int unsigned       pick;
    logic [SENS_W-1:0] s;
    bit                held;
    held = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dir_rows.push_back(row(OP_READ, 0, 0, 1, result_of(0, 0, 0, 0, 0, 1, 0, 0, 0)));
    dir_rows.push_back(row(OP_READ, 0, 255, 1, '0));
    dir_rows.push_back(row(OP_SPARE_LO, 15, 128, 1, '0));
    dir_rows.push_back(row(OP_SPARE_HI, 7, 127, 1, '0));
    dir_rows.push_back(row(OP_TICK, 0, 0, 1, '0));
    dir_rows.push_back(row(OP_FALL, 0, 0, 1, result_of(1, 1, 1, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(OP_RISE, 2, 0, 1, result_of(0, 0, 0, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(OP_START, 0, 0, 1, result_of(1, 0, 0, 0, 0, 0, 0, 0, 0)));
    run_rows();

    settle();
    write_cfg(16'd1, 24'd2, 16'hFFFF);
    dir_rows.push_back(row(OP_RISE, 0, 0));
    dir_rows.push_back(row(OP_TICK, 0, 0));
    dir_rows.push_back(row(OP_FALL, 0, 0));
    dir_rows.push_back(row(OP_RISE, 1, 0));
    dir_rows.push_back(row(OP_TICK, 0, 0));
    dir_rows.push_back(row(OP_TICK, 0, 0));
    dir_rows.push_back(row(OP_RISE, 2, 0));
    dir_rows.push_back(row(OP_TICK, 0, 0));
    dir_rows.push_back(row(OP_RISE, 2, 0));
    dir_rows.push_back(row(OP_FALL, 2, 0));
    dir_rows.push_back(row(OP_FALL, 3, 0));
    dir_rows.push_back(row(OP_RISE, 0, 0));
    dir_rows.push_back(row(OP_START, 0, 0));
    dir_rows.push_back(row(OP_READ, 0, 1));
    dir_rows.push_back(row(OP_READ, 0, 4));
    run_rows();

    settle();
    write_cfg(16'd0, 24'd0, 16'd0);
    dir_rows.push_back(row(OP_START, 0, 0));
    dir_rows.push_back(row(OP_RISE, 0, 0));
    dir_rows.push_back(row(OP_TICK, 0, 0));
    dir_rows.push_back(row(OP_RISE, 1, 0));
    dir_rows.push_back(row(OP_FALL, 1, 0));
    run_rows();

    // long echo under the longest timeout
    settle();
    write_cfg(16'd1, 24'hFFFFFF, DIST_W'($urandom));
    issue(OP_START, 0, 0);
    issue(OP_RISE, 0, 0);
    repeat (BURST_TICKS) issue(OP_TICK, SENS_W'($urandom_range(15)), RIDX_W'($urandom));
    issue(OP_FALL, 0, 0);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          write_cfg(DIST_W'($urandom_range(1, 16)), TMO_W'($urandom_range(1, 24)),
                    DIST_W'($urandom));
        end
        1: begin
          send_idle_pct = 56;
          stall_pct = 0;
          write_cfg(16'hFFFF, TMO_W'($urandom_range(1, 24)), 16'hFFFF);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 56;
          write_cfg(DIST_W'($urandom_range(1, 300)), TMO_W'($urandom_range(1, 24)),
                    DIST_W'($urandom));
        end
        default: begin
          send_idle_pct = 36;
          stall_pct = 36;
          write_cfg(DIST_W'($urandom_range(1, 65535)), TMO_W'($urandom_range(1, 24)),
                    DIST_W'($urandom));
        end
      endcase
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          s = scan_pos;
          if ($urandom_range(3) == 0) begin
            issue(OP_RISE, SENS_W'($urandom_range(15)), RIDX_W'($urandom));
            cnt++;
          end
          issue(OP_RISE, s, RIDX_W'($urandom));
          cnt++;
          if ($urandom_range(9) == 0) begin
            issue(OP_TICK, SENS_W'($urandom_range(15)), RIDX_W'($urandom));
            issue(OP_RISE, s, RIDX_W'($urandom));
            cnt += 2;
          end
          n = $urandom_range(tmo_reg + 1);
          repeat (n) begin
            issue(OP_TICK, SENS_W'($urandom_range(15)), RIDX_W'($urandom));
            cnt++;
          end
          if (armed && scan_pos == s) begin
            issue(OP_FALL, s, RIDX_W'($urandom));
            cnt++;
          end
        end else if (pick < 85) begin
          issue(OP_READ, SENS_W'($urandom_range(15)),
                $urandom_range(1) ? RIDX_W'($urandom_range(SENSORS - 1)) : RIDX_W'($urandom));
          cnt++;
        end else if (pick < 90) begin
          issue(OP_START, SENS_W'($urandom_range(15)), RIDX_W'($urandom));
          cnt++;
        end else begin
          issue(OP_W'($urandom_range(7)), SENS_W'($urandom_range(15)), RIDX_W'($urandom));
          cnt++;
        end
        // hold the output while the sender keeps offering transactions
        if (p == 0 && !held && cnt >= 100) begin
          hold_go = 1'b1;
          held = 1'b1;
        end
      end
    end

    settle();
    errors += pending_results.size();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* multiplexed_echo_ranger_top.f */
src/mer_pkg.sv
src/mer_ram.sv
src/multiplexed_echo_ranger_top.sv
src/mer_checker.sv
bench/testbench.sv
